>>> rtl/jbcd_pkg.sv
`timescale 1ns / 1ps

package jbcd_pkg;

  // Block geometry
  localparam int BLOCK_COEFFS   = 64;
  localparam int LAST_POS       = BLOCK_COEFFS - 1;
  localparam int NUM_COMPONENTS = 4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Largest legal DC size
  localparam logic [7:0] DC_SIZE_MAX = 8'd16;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RUN   = 2'd1,
    ERR_TRAIL = 2'd2,
    ERR_SIZE  = 2'd3
  } err_e;

  // Classified word handed from front to back
  typedef struct packed {
    logic        dc_add;     // add value to the component predictor
    logic [1:0]  component;
    logic        restart;
    logic [6:0]  position;
    logic [15:0] value;      // extended signed value, zero where no coefficient
    logic        block_end;
    err_e        error;
  } jbcd_item_t;

  // JPEG EXTEND of the low size bits, reduced to 16 bits (size 0..16)
  function automatic logic [15:0] extend_value(logic [4:0] size, logic [15:0] bits);
    logic [16:0] span;
    logic [15:0] mask;
    logic [15:0] half;
    logic [15:0] v;
    logic [16:0] r;
    span = 17'(1) << size;
    mask = 16'(span - 17'd1);
    half = 16'(span >> 1);
    v    = bits & mask;
    if ((v & half) != 16'd0) begin
      r = {1'b0, v};
    end else begin
      r = {1'b0, v} - span + 17'd1;
    end
    return r[15:0];
  endfunction

endpackage

>>> rtl/jbcd_front.sv
`timescale 1ns / 1ps

module jbcd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             symbol_i,
  input  logic [15:0]            extra_bits_i,
  input  logic [1:0]             component_i,
  input  logic                   restart_i,
  input  logic                   q_full_i,
  output logic                   q_wr_o,
  output jbcd_pkg::jbcd_item_t   q_item_o
);

  // Block state: next zigzag position (0 means a DC size is expected)
  logic [5:0] next_pos_q, next_pos_d;
  logic       last_zero_q, last_zero_d;

  logic       accept;
  logic       is_dc;
  logic [3:0] run;
  logic [3:0] ac_size;
  logic [6:0] p;
  logic       ac_zero;
  logic [4:0] ext_size;
  logic [15:0] ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_wr_o     = accept;

  assign is_dc    = (next_pos_q == 6'd0);
  assign run      = symbol_i[7:4];
  assign ac_size  = symbol_i[3:0];
  assign p        = {1'b0, next_pos_q} + {3'b000, run};
  assign ac_zero  = (ac_size == 4'd0);
  assign ext_size = is_dc ? symbol_i[4:0] : {1'b0, ac_size};
  assign ext      = jbcd_pkg::extend_value(ext_size, extra_bits_i);

  // Classify the word and work out the next block state
  always_comb begin
    q_item_o.dc_add    = 1'b0;
    q_item_o.component = component_i;
    q_item_o.restart   = restart_i;
    q_item_o.position  = 7'd0;
    q_item_o.value     = 16'd0;
    q_item_o.block_end = 1'b0;
    q_item_o.error     = jbcd_pkg::ERR_NONE;
    next_pos_d         = next_pos_q;
    last_zero_d        = last_zero_q;
    if (is_dc) begin
      if (symbol_i > jbcd_pkg::DC_SIZE_MAX) begin
        q_item_o.block_end = 1'b1;
        q_item_o.error     = jbcd_pkg::ERR_SIZE;
        next_pos_d         = 6'd0;
        last_zero_d        = 1'b0;
      end else begin
        q_item_o.dc_add = 1'b1;
        q_item_o.value  = ext;
        next_pos_d      = 6'd1;
        last_zero_d     = 1'b0;
      end
    end else if (symbol_i == 8'd0) begin
      // end of block
      q_item_o.position  = {1'b0, next_pos_q};
      q_item_o.block_end = 1'b1;
      if (last_zero_q) begin
        q_item_o.error = jbcd_pkg::ERR_TRAIL;
      end
      next_pos_d  = 6'd0;
      last_zero_d = 1'b0;
    end else if (p > 7'(jbcd_pkg::LAST_POS)) begin
      q_item_o.position  = 7'(jbcd_pkg::BLOCK_COEFFS);
      q_item_o.block_end = 1'b1;
      q_item_o.error     = jbcd_pkg::ERR_RUN;
      next_pos_d         = 6'd0;
      last_zero_d        = 1'b0;
    end else begin
      q_item_o.position = p;
      q_item_o.value    = ext;
      if (p == 7'(jbcd_pkg::LAST_POS)) begin
        q_item_o.block_end = 1'b1;
        if (ac_zero) begin
          q_item_o.error = jbcd_pkg::ERR_TRAIL;
        end
        next_pos_d  = 6'd0;
        last_zero_d = 1'b0;
      end else begin
        next_pos_d  = p[5:0] + 6'd1;
        last_zero_d = ac_zero;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_pos_q  <= 6'd0;
      last_zero_q <= 1'b0;
    end else if (accept) begin
      next_pos_q  <= next_pos_d;
      last_zero_q <= last_zero_d;
    end
  end

  // A zero AC write is only remembered inside a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_zero_q |-> (next_pos_q != 6'd0))
    else $error("trailing-zero flag set while expecting DC");

  // Every error closes the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_wr_o && (q_item_o.error != jbcd_pkg::ERR_NONE)) |-> q_item_o.block_end)
    else $error("error word without block end");

  // An error or block end leaves the front expecting DC
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_wr_o && q_item_o.block_end) |=> (next_pos_q == 6'd0))
    else $error("block end did not return to DC");

endmodule

>>> rtl/jbcd_queue.sv
`timescale 1ns / 1ps

module jbcd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_i,
  input  jbcd_pkg::jbcd_item_t   wr_item_i,
  output logic                   full_o,
  input  logic                   rd_i,
  output logic                   valid_o,
  output jbcd_pkg::jbcd_item_t   rd_item_o
);

  jbcd_pkg::jbcd_item_t             mem_q [jbcd_pkg::QUEUE_DEPTH];
  logic [jbcd_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [jbcd_pkg::QCNT_W-1:0]      count_q;

  assign full_o    = (count_q == jbcd_pkg::QCNT_W'(jbcd_pkg::QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign rd_item_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_i |-> valid_o)
    else $error("queue underflow");

endmodule

>>> rtl/jbcd_back.sv
`timescale 1ns / 1ps

module jbcd_back #(
  parameter int NUM_COMPONENTS = jbcd_pkg::NUM_COMPONENTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  jbcd_pkg::jbcd_item_t   q_item_i,
  output logic                   q_rd_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [6:0]             position_o,
  output logic [15:0]            coefficient_o,
  output logic                   block_end_o,
  output jbcd_pkg::err_e         error_o
);

  localparam int IDX_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  logic [15:0]      pred_q [NUM_COMPONENTS];
  logic [IDX_W-1:0] idx;
  logic [15:0]      base;
  logic [15:0]      sum;
  logic             out_valid_q;
  logic [6:0]       position_q;
  logic [15:0]      coefficient_q;
  logic             block_end_q;
  jbcd_pkg::err_e   error_q;

  // Take the next word when the output register is free or being drained
  assign q_rd_o = q_valid_i && (!out_valid_q || out_ready_i);

  // Out-of-range components share the last predictor
  assign idx  = ({30'd0, q_item_i.component} >= 32'(NUM_COMPONENTS)) ?
                IDX_W'(NUM_COMPONENTS - 1) : IDX_W'(q_item_i.component);
  assign base = q_item_i.restart ? 16'd0 : pred_q[idx];
  assign sum  = base + q_item_i.value;

  // DC predictors: restart clears all, then the DC add lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        pred_q[i] <= 16'd0;
      end
    end else if (q_rd_o) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        if (q_item_i.dc_add && (IDX_W'(i) == idx)) begin
          pred_q[i] <= sum;
        end else if (q_item_i.restart) begin
          pred_q[i] <= 16'd0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_rd_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      position_q    <= q_item_i.position;
      coefficient_q <= q_item_i.dc_add ? sum : q_item_i.value;
      block_end_q   <= q_item_i.block_end;
      error_q       <= q_item_i.error;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign position_o    = position_q;
  assign coefficient_o = coefficient_q;
  assign block_end_o   = block_end_q;
  assign error_o       = error_q;

  // A restart without a DC add leaves every predictor at zero (checked on predictor 0)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_rd_o && q_item_i.restart && !q_item_i.dc_add) |=> (pred_q[0] == 16'd0))
    else $error("restart did not clear predictors");

  // DC results carry position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_rd_o && q_item_i.dc_add) |=> (position_q == 7'd0 && !block_end_q))
    else $error("DC result misplaced");

endmodule

>>> rtl/jpeg_baseline_coefficient_decode.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                            tlast      tuser
// s_axis    in   symbol[7:0] extra_bits[23:8] component[25:24] -          restart
// m_axis    out  position[6:0] coefficient[22:7]               block_end  error
//
// One word in, one word out; a word is taken every cycle when the output drains.
// Each word is classified into a two-entry queue, then the predictor add writes it
// into the output register. The predictor add sets the back-stage path.
// Reset (rst_ni low, async) clears predictors, block state and the queue.
// An output stall fills the queue; tready drops only when it is full.

module jpeg_baseline_coefficient_decode #(
  parameter int NUM_COMPONENTS = jbcd_pkg::NUM_COMPONENTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // symbol, extra_bits, component
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // position, coefficient
  output logic        m_axis_tlast,   // block_end
  output logic [1:0]  m_axis_tuser    // error
);

  logic                   q_full;
  logic                   q_wr;
  logic                   q_rd;
  logic                   q_valid;
  jbcd_pkg::jbcd_item_t   q_wr_item;
  jbcd_pkg::jbcd_item_t   q_rd_item;
  logic [6:0]             position;
  logic [15:0]            coefficient;
  jbcd_pkg::err_e         error;

  jbcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .symbol_i     (s_axis_tdata[7:0]),
    .extra_bits_i (s_axis_tdata[23:8]),
    .component_i  (s_axis_tdata[25:24]),
    .restart_i    (s_axis_tuser),
    .q_full_i     (q_full),
    .q_wr_o       (q_wr),
    .q_item_o     (q_wr_item)
  );

  jbcd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (q_wr_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_item_o (q_rd_item)
  );

  jbcd_back #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_rd_item),
    .q_rd_o        (q_rd),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .position_o    (position),
    .coefficient_o (coefficient),
    .block_end_o   (m_axis_tlast),
    .error_o       (error)
  );

  assign m_axis_tdata = {1'b0, coefficient, position};
  assign m_axis_tuser = error;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 8;
  localparam logic [7:0]  EOB_SYMBOL  = 8'h00;
  localparam logic [7:0]  ZRL_SYMBOL  = 8'hF0;

  // One decoded coefficient word as seen on the output stream
  typedef struct {
    logic [6:0]      position;
    logic [15:0]     coefficient;
    logic            block_end;
    jbcd_pkg::err_e  error;
  } coef_word_t;

  // Scoreboard: tracks block state and DC predictors, holds expected words
  class coef_scoreboard;
    logic [15:0] dc_pred [jbcd_pkg::NUM_COMPONENTS];
    logic [6:0]  next_pos;
    bit          last_zero;
    coef_word_t  expected_q [$];
    int          mismatches;

    function new();
      for (int i = 0; i < jbcd_pkg::NUM_COMPONENTS; i++) dc_pred[i] = '0;
      next_pos   = '0;
      last_zero  = 1'b0;
      mismatches = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    // JPEG EXTEND of the low size bits, wrapped to 16 bits
    function logic [15:0] extend_bits(int unsigned size, logic [15:0] bits);
      logic [31:0] v;
      logic [31:0] span;
      if (size == 0 || size > 16) return 16'd0;
      span = 32'd1 << size;
      v    = {16'd0, bits} & (span - 32'd1);
      if (v < (span >> 1)) v = v - span + 32'd1;
      return v[15:0];
    endfunction

    function void close_block();
      next_pos  = '0;
      last_zero = 1'b0;
    endfunction

    // Accepted input symbol: advance the model and queue the expected word
    function void note_symbol(logic [7:0] sym, logic [15:0] extra, logic [1:0] comp,
                              logic restart);
      coef_word_t  w;
      int unsigned ci;
      int unsigned run;
      int unsigned p;
      logic [15:0] v;
      w.position    = '0;
      w.coefficient = '0;
      w.block_end   = 1'b0;
      w.error       = jbcd_pkg::ERR_NONE;
      ci = (32'(comp) >= jbcd_pkg::NUM_COMPONENTS) ? jbcd_pkg::NUM_COMPONENTS - 1 :
           32'(comp);
      if (restart) begin
        for (int i = 0; i < jbcd_pkg::NUM_COMPONENTS; i++) dc_pred[i] = '0;
      end
      if (next_pos == 7'd0 || 32'(next_pos) >= jbcd_pkg::BLOCK_COEFFS) begin
        // DC size symbol
        if (sym > jbcd_pkg::DC_SIZE_MAX) begin
          w.block_end = 1'b1;
          w.error     = jbcd_pkg::ERR_SIZE;
          close_block();
        end else begin
          dc_pred[ci]   = dc_pred[ci] + extend_bits(32'(sym), extra);
          w.coefficient = dc_pred[ci];
          next_pos      = 7'd1;
          last_zero     = 1'b0;
        end
      end else if (sym == EOB_SYMBOL) begin
        w.position  = next_pos;
        w.block_end = 1'b1;
        if (last_zero) w.error = jbcd_pkg::ERR_TRAIL;
        close_block();
      end else begin
        // AC run/size
        run = 32'(sym[7:4]);
        p   = 32'(next_pos) + run;
        if (p > 32'(jbcd_pkg::LAST_POS)) begin
          w.position  = 7'(jbcd_pkg::BLOCK_COEFFS);
          w.block_end = 1'b1;
          w.error     = jbcd_pkg::ERR_RUN;
          close_block();
        end else begin
          v             = extend_bits(32'(sym[3:0]), extra);
          w.coefficient = v;
          w.position    = 7'(p);
          last_zero     = (v == 16'd0);
          if (p == 32'(jbcd_pkg::LAST_POS)) begin
            w.block_end = 1'b1;
            if (last_zero) w.error = jbcd_pkg::ERR_TRAIL;
            close_block();
          end else begin
            next_pos = 7'(p + 1);
          end
        end
      end
      expected_q.push_back(w);
    endfunction

    // Accepted output word: compare with the oldest expectation
    task check_word(logic [6:0] pos, logic [15:0] coef, logic bend, logic [1:0] err);
      coef_word_t w;
      if (expected_q.size() == 0) begin
        report("unexpected word, position", 32'(pos), 32'd0);
        return;
      end
      w = expected_q.pop_front();
      if (pos !== w.position) report("position", 32'(pos), 32'(w.position));
      if (coef !== w.coefficient) report("coefficient", 32'(coef), 32'(w.coefficient));
      if (bend !== w.block_end) report("block_end", 32'(bend), 32'(w.block_end));
      if (err !== w.error) report("error", 32'(err), 32'(w.error));
    endtask

    task flush_leftover();
      coef_word_t w;
      while (expected_q.size() != 0) begin
        w = expected_q.pop_front();
        report("missing word, position", 32'd0, 32'(w.position));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // symbol, extra_bits, component
  logic        s_axis_tuser = 1'b0; // restart
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // position, coefficient
  logic        m_axis_tlast;        // block_end
  logic [1:0]  m_axis_tuser;        // error

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_left     = 0;
  int cycles        = 0;

  coef_scoreboard sb = new();

  jpeg_baseline_coefficient_decode dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: check accepted words, random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata[6:0], m_axis_tdata[22:7], m_axis_tlast, m_axis_tuser);
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one symbol word, return once it is taken
  task automatic send_word(input logic [7:0] sym, input logic [15:0] extra,
                           input logic [1:0] comp, input logic restart);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, comp, extra, sym};
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_symbol(sym, extra, comp, restart);
  endtask

  // Mostly well-formed blocks, some noise symbols
  task automatic send_random();
    logic [7:0]  sym;
    logic [3:0]  run;
    logic [3:0]  size;
    logic [15:0] extra;
    logic [1:0]  comp;
    logic        restart;
    int          r;
    extra   = 16'($urandom);
    comp    = 2'($urandom_range(3));
    restart = ($urandom_range(99) < 4);
    r       = int'($urandom_range(99));
    if (r < 8) begin
      sym = 8'($urandom_range(255));
    end else if (sb.next_pos == 7'd0) begin
      sym = ($urandom_range(99) < 4) ? 8'($urandom_range(255, 17)) :
            8'($urandom_range(16));
    end else begin
      r = int'($urandom_range(99));
      if (r < 15) begin
        sym = EOB_SYMBOL;
      end else begin
        run  = (r < 75) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        size = ($urandom_range(9) == 0) ? 4'd0 : 4'($urandom_range(15, 1));
        if (run == 4'd0 && size == 4'd0) size = 4'd1;
        sym = {run, size};
      end
    end
    send_word(sym, extra, comp, restart);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender rarely idles, receiver often stalls
    src_idle_pct  = 7;
    sink_idle_pct = 56;

    // DC size zero, AC run/size words, ZRL, EOB after a zero
    send_word(8'd0, 16'hFFFF, 2'd0, 1'b0);
    send_word(8'd16, 16'hFFFF, 2'd1, 1'b0);
    send_word(8'h01, 16'h0000, 2'd1, 1'b0);
    send_word(ZRL_SYMBOL, 16'hFFFF, 2'd1, 1'b0);
    send_word(EOB_SYMBOL, 16'h0000, 2'd1, 1'b0);
    // bad DC size with restart
    send_word(8'd17, 16'h1234, 2'd3, 1'b1);
    // DC size 16 wrapping, then a block that ends at the last position
    send_word(8'd16, 16'h0000, 2'd2, 1'b0);
    send_word(8'hFF, 16'h7FFF, 2'd2, 1'b0);
    send_word(8'hFA, 16'h03FF, 2'd2, 1'b0);
    send_word(8'hFA, 16'hFC00, 2'd2, 1'b0);
    send_word(8'hE5, 16'h0010, 2'd2, 1'b0);
    send_word(8'hFF, 16'hFFFF, 2'd3, 1'b0);
    // run past the end of the block
    send_word(8'd3, 16'h0005, 2'd3, 1'b0);
    send_word(8'hF1, 16'h0001, 2'd3, 1'b0);
    send_word(8'hF1, 16'h0000, 2'd3, 1'b0);
    send_word(8'hF1, 16'h0001, 2'd3, 1'b0);
    send_word(8'hF1, 16'h0001, 2'd3, 1'b0);
    // zero coefficient landing on the last position
    send_word(8'd1, 16'h0001, 2'd0, 1'b0);
    send_word(8'hE0, 16'h0000, 2'd0, 1'b0);
    send_word(ZRL_SYMBOL, 16'h0000, 2'd0, 1'b0);
    send_word(ZRL_SYMBOL, 16'h0000, 2'd0, 1'b0);
    send_word(ZRL_SYMBOL, 16'h0000, 2'd0, 1'b0);
    // restart in the middle of a block keeps the block going
    send_word(8'd2, 16'h0002, 2'd0, 1'b0);
    send_word(8'h11, 16'h0001, 2'd0, 1'b1);
    send_word(EOB_SYMBOL, 16'h0000, 2'd0, 1'b0);
    send_word(8'd0, 16'h0000, 2'd1, 1'b0);

    // Long receiver hold-off while the sender keeps going
    hold_left = 150;
    repeat (40) send_random();
    repeat (160) send_random();
    drain();

    // Phase two: sender often idles, receiver rarely stalls
    src_idle_pct  = 56;
    sink_idle_pct = 7;
    repeat (200) send_random();
    drain();

    // Phase three: full rate
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (200) send_random();
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.flush_leftover();
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/jbcd_pkg.sv
rtl/jbcd_front.sv
rtl/jbcd_queue.sv
rtl/jbcd_back.sv
rtl/jpeg_baseline_coefficient_decode.sv
tb/tb_top.sv
